[rtl/core/vdw_pkg.sv]
// ----------------------------------------------------------------------------
// vdw_pkg
// Shared widths and constants for the 12-6 pair energy and gradient pipeline.
// ----------------------------------------------------------------------------
package vdw_pkg;

    // multiplier limb width
    localparam int LIMB_W   = 32;
    // fraction bits dropped after each power of x^2
    localparam int FRAC_W   = 32;

    localparam int IDX_W    = 12;
    localparam int POS_W    = 32;
    localparam int PRM_W    = 16;

    // |rij| component below the far limit
    localparam int MAG_W    = 24;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int B_W      = SQ_W + 2;
    localparam int A_W      = 2 * PRM_W;

    // powers of x^2
    localparam int S_W      = 40;
    localparam int S2_W     = 48;
    localparam int X6_W     = 56;
    localparam int X12_W    = 80;

    // mixed well depth and 12*D
    localparam int D_W      = 16;
    localparam int D12_W    = D_W + 4;
    localparam int UD_W     = X12_W + D12_W;
    localparam int N_W      = UD_W + MAG_W;
    // gradient quotient bits kept before the final shift
    localparam int GQ_W     = 44;
    localparam int G_SH     = 12;
    localparam int E_SH     = 28;

    localparam int DIV_BPS  = 4;
    localparam int ISQ_SPS  = 2;
    localparam int MUL_LAT  = 2;

    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] NEG_MAX = 32'h8000_0000;

endpackage

[rtl/core/vdw_dly.sv]
// ----------------------------------------------------------------------------
// vdw_dly
// Fixed-depth register delay line for words that ride beside the datapath.
// ----------------------------------------------------------------------------
module vdw_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sr [N];

    // shift one stage per clock
    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
        for (int k = 1; k < N; k++) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_d = r_sr[N-1];

endmodule

[rtl/core/vdw_mul.sv]
// ----------------------------------------------------------------------------
// vdw_mul
// Unsigned multiplier split into 32x32 limb products, two register stages.
// ----------------------------------------------------------------------------
module vdw_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             i_clk,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);

    localparam int LW = vdw_pkg::LIMB_W;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int PW = LW * (NA + NB);

    logic [NA*LW-1:0]  a_pad;
    logic [NB*LW-1:0]  b_pad;
    logic [2*LW-1:0]   r_pp [NA*NB];
    logic [PW-1:0]     n_sum;
    logic [WA+WB-1:0]  r_p;

    assign a_pad = (NA*LW)'(i_a);
    assign b_pad = (NB*LW)'(i_b);

    // stage 1: limb products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i*NB+j] <= a_pad[i*LW +: LW] * b_pad[j*LW +: LW];
            end
        end
    end

    // stage 2: align and sum
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (PW'(r_pp[i*NB+j]) << (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_sum[WA+WB-1:0];
    end

    assign o_p = r_p;

endmodule

[rtl/core/vdw_div.sv]
// ----------------------------------------------------------------------------
// vdw_div
// Pipelined restoring divider: a running remainder below the divisor takes
// NQ more numerator bits, BPS quotient bits per register stage.
// ----------------------------------------------------------------------------
module vdw_div #(
    parameter int WD  = 50,
    parameter int NQ  = 40,
    parameter int BPS = 4
) (
    input  logic          i_clk,
    input  logic [WD-1:0] i_rem,
    input  logic [NQ-1:0] i_lo,
    input  logic [WD-1:0] i_den,
    output logic [NQ-1:0] o_q
);

    localparam int NS = (NQ + BPS - 1) / BPS;

    logic [WD-1:0] r_rem [NS];
    logic [WD-1:0] r_den [NS];
    logic [NQ-1:0] r_lo  [NS];
    logic [NQ-1:0] r_q   [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [WD-1:0] rem_in;
        logic [WD-1:0] den_in;
        logic [NQ-1:0] lo_in;
        logic [NQ-1:0] q_in;
        logic [WD-1:0] n_rem;
        logic [NQ-1:0] n_lo;
        logic [NQ-1:0] n_q;
        logic [WD:0]   trial;

        if (g == 0) begin : g_first
            assign rem_in = i_rem;
            assign den_in = i_den;
            assign lo_in  = i_lo;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign lo_in  = r_lo[g-1];
            assign q_in   = r_q[g-1];
        end

        // BPS shift-compare-subtract steps
        always_comb begin
            n_rem = rem_in;
            n_lo  = lo_in;
            n_q   = q_in;
            trial = '0;
            for (int b = 0; b < BPS; b++) begin
                if (g * BPS + b < NQ) begin
                    trial = {n_rem, n_lo[NQ-1]};
                    n_lo  = n_lo << 1;
                    if (trial >= {1'b0, den_in}) begin
                        trial = trial - {1'b0, den_in};
                        n_q   = {n_q[NQ-2:0], 1'b1};
                    end else begin
                        n_q   = {n_q[NQ-2:0], 1'b0};
                    end
                    n_rem = trial[WD-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_den[g] <= den_in;
            r_lo[g]  <= n_lo;
            r_q[g]   <= n_q;
        end
    end

    assign o_q = r_q[NS-1];

endmodule

[rtl/core/vdw_isqrt.sv]
// ----------------------------------------------------------------------------
// vdw_isqrt
// Pipelined integer square root (floor), SPS result bits per register stage.
// ----------------------------------------------------------------------------
module vdw_isqrt #(
    parameter int WR  = 16,
    parameter int SPS = 2
) (
    input  logic            i_clk,
    input  logic [2*WR-1:0] i_v,
    output logic [WR-1:0]   o_r
);

    localparam int WV = 2 * WR;
    localparam int NS = (WR + SPS - 1) / SPS;

    logic [WV-1:0] r_v   [NS];
    logic [WV-1:0] r_res [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [WV-1:0] v_in;
        logic [WV-1:0] res_in;
        logic [WV-1:0] n_v;
        logic [WV-1:0] n_res;
        logic [WV-1:0] one_b;
        logic [WV:0]   trial;

        if (g == 0) begin : g_first
            assign v_in   = i_v;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign res_in = r_res[g-1];
        end

        // digit-by-digit root, two bits of radicand per step
        always_comb begin
            n_v   = v_in;
            n_res = res_in;
            one_b = '0;
            trial = '0;
            for (int b = 0; b < SPS; b++) begin
                if (g * SPS + b < WR) begin
                    one_b = WV'(1) << (WV - 2 - 2 * (g * SPS + b));
                    trial = {1'b0, n_res} + {1'b0, one_b};
                    if ({1'b0, n_v} >= trial) begin
                        n_v   = n_v - trial[WV-1:0];
                        n_res = (n_res >> 1) + one_b;
                    end else begin
                        n_res = n_res >> 1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_v[g]   <= n_v;
            r_res[g] <= n_res;
        end
    end

    assign o_r = r_res[NS-1][WR-1:0];

endmodule

[rtl/core/vdw_pair_energy_force.sv]
// ----------------------------------------------------------------------------
// vdw_pair_energy_force
// Lennard-Jones 12-6 energy and gradient for one atom pair per clock.
// ----------------------------------------------------------------------------
// Use: drive one pair word with i_start high; o_busy is always low, so every
// start is taken. Each pair gives exactly one result word, shown on the o_
// result ports for one cycle with o_valid high, in input order.
// The pipeline depth is T_OUT below, with four divider bits per stage. The
// restoring divider for x^2 = xij^2 / r^2, the three gradient dividers over
// r^2 and the chain of three limb multiplies for x^6 and x^12 set that depth.
// Throughput: one pair per cycle, no bubbles.
// Reset (synchronous, active low) clears the valid pipeline; words in flight
// are dropped. Results cannot be held off by the receiver, and nothing in the
// pipeline ever waits on it.
// Coincident atoms are flagged skipped; far pairs give zero; deep overlap
// at nonzero well depth and out-of-range values saturate, raise o_saturated.
// ----------------------------------------------------------------------------
module vdw_pair_energy_force #(
    parameter int DIV_BPS = vdw_pkg::DIV_BPS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [vdw_pkg::IDX_W-1:0]   i_atom_i_index,
    input  logic [vdw_pkg::IDX_W-1:0]   i_atom_j_index,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_i_x,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_i_y,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_i_z,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_j_x,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_j_y,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_j_z,
    input  logic [vdw_pkg::PRM_W-1:0]   i_dist_param_i,
    input  logic [vdw_pkg::PRM_W-1:0]   i_dist_param_j,
    input  logic [vdw_pkg::PRM_W-1:0]   i_well_depth_i,
    input  logic [vdw_pkg::PRM_W-1:0]   i_well_depth_j,
    output logic                        o_valid,
    output logic [vdw_pkg::IDX_W-1:0]   o_out_atom_i,
    output logic [vdw_pkg::IDX_W-1:0]   o_out_atom_j,
    output logic signed [vdw_pkg::POS_W-1:0] o_pair_energy,
    output logic signed [vdw_pkg::POS_W-1:0] o_grad_x,
    output logic signed [vdw_pkg::POS_W-1:0] o_grad_y,
    output logic signed [vdw_pkg::POS_W-1:0] o_grad_z,
    output logic                        o_skipped,
    output logic                        o_saturated
);

    localparam int PW    = vdw_pkg::POS_W;
    localparam int MW    = vdw_pkg::MAG_W;
    localparam int BW    = vdw_pkg::B_W;
    localparam int FW    = vdw_pkg::FRAC_W;
    localparam int ML    = vdw_pkg::MUL_LAT;

    localparam int DV1_NS = (vdw_pkg::S_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DV2_NS = (vdw_pkg::GQ_W + DIV_BPS - 1) / DIV_BPS;
    localparam int ISQ_NS = (vdw_pkg::D_W + vdw_pkg::ISQ_SPS - 1) / vdw_pkg::ISQ_SPS;

    // stage numbers, counted in registers after the input edge
    localparam int T_A    = 1;
    localparam int T_SQ   = T_A + ML;
    localparam int T_B    = T_SQ + 1;
    localparam int T_OV   = T_B + 1;
    localparam int T_S    = T_B + DV1_NS;
    localparam int T_S2   = T_S + ML;
    localparam int T_X6   = T_S2 + ML;
    localparam int T_X12  = T_X6 + ML;
    localparam int T_TU   = T_X12 + 1;
    localparam int T_E    = T_TU + ML;
    localparam int T_EC   = T_E + 1;
    localparam int T_N    = T_E + ML;
    localparam int T_G    = T_N + 1;
    localparam int T_Q    = T_G + DV2_NS;
    localparam int T_OUT  = T_Q + 1;
    localparam int T_D    = T_A + ISQ_NS + 1;

    typedef struct packed {
        logic [vdw_pkg::IDX_W-1:0] idx_i;
        logic [vdw_pkg::IDX_W-1:0] idx_j;
        logic                      zero;
        logic                      far;
        logic                      pz;
        logic [2:0]                dneg;
        logic [2:0]                dnz;
    } t_side;

    // saturate a sign/magnitude value to Q16.16; top bit is the clip flag
    function automatic logic [PW:0] f_clip(input logic neg, input logic hi,
                                           input logic [PW-1:0] lo);
        logic [PW:0] res;
        if (!neg) begin
            res = (hi || lo > vdw_pkg::POS_MAX) ? {1'b1, vdw_pkg::POS_MAX} : {1'b0, lo};
        end else begin
            res = (hi || lo > vdw_pkg::NEG_MAX) ? {1'b1, vdw_pkg::NEG_MAX} : {1'b0, -lo};
        end
        return res;
    endfunction

    logic [PW-1:0]          pos_i [3];
    logic [PW-1:0]          pos_j [3];
    logic [PW:0]            d_raw [3];
    logic [PW:0]            d_mag [3];
    logic [2:0]             n_far_c;
    logic [2:0]             n_dnz;

    logic [T_OUT-1:0]       r_vld;
    logic [MW-1:0]          r_mag [3];
    t_side                  r_side;
    t_side                  side_q;
    logic [vdw_pkg::A_W-1:0] r_a;
    logic [vdw_pkg::A_W-1:0] r_p;
    logic [vdw_pkg::A_W-1:0] a_b;

    assign o_busy = 1'b0;

    assign pos_i[0] = i_pos_i_x;
    assign pos_i[1] = i_pos_i_y;
    assign pos_i[2] = i_pos_i_z;
    assign pos_j[0] = i_pos_j_x;
    assign pos_j[1] = i_pos_j_y;
    assign pos_j[2] = i_pos_j_z;

    // rij and its magnitude, exact in 33 bits
    for (genvar c = 0; c < 3; c++) begin : g_rij
        assign d_raw[c]   = {pos_i[c][PW-1], pos_i[c]} - {pos_j[c][PW-1], pos_j[c]};
        assign d_mag[c]   = d_raw[c][PW] ? -d_raw[c] : d_raw[c];
        assign n_far_c[c] = |d_mag[c][PW:MW];
        assign n_dnz[c]   = |d_mag[c];
    end

    // stage A: rij, parameter products, pair classification
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_mag[c] <= d_mag[c][MW-1:0];
        end
        r_a          <= i_dist_param_i * i_dist_param_j;
        r_p          <= i_well_depth_i * i_well_depth_j;
        r_side.idx_i <= i_atom_i_index;
        r_side.idx_j <= i_atom_j_index;
        r_side.zero  <= ~|n_dnz;
        r_side.far   <= |n_far_c;
        r_side.pz    <= (i_well_depth_i == '0) || (i_well_depth_j == '0);
        r_side.dneg  <= {d_raw[2][PW], d_raw[1][PW], d_raw[0][PW]};
        r_side.dnz   <= n_dnz;
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[T_OUT-2:0], i_start & ~o_busy};
        end
    end

    // r^2 = sum of squares
    logic [vdw_pkg::SQ_W-1:0] sq [3];
    logic [BW-1:0]            r_b;
    logic                     r_ovl;
    logic                     ovl_q;

    for (genvar c = 0; c < 3; c++) begin : g_sq
        vdw_mul #(.WA(MW), .WB(MW)) u_sq (
            .i_clk (i_clk),
            .i_a   (r_mag[c]),
            .i_b   (r_mag[c]),
            .o_p   (sq[c])
        );
    end

    vdw_dly #(.W(vdw_pkg::A_W), .N(T_B - T_A)) u_dly_a (
        .i_clk (i_clk), .i_d (r_a), .o_d (a_b)
    );

    always_ff @(posedge i_clk) begin
        r_b   <= BW'(sq[0]) + BW'(sq[1]) + BW'(sq[2]);
        r_ovl <= BW'(a_b) >= r_b;
    end

    vdw_dly #(.W(1), .N(T_Q - T_OV)) u_dly_ovl (
        .i_clk (i_clk), .i_d (r_ovl), .o_d (ovl_q)
    );

    // s = xij^2 * 2^40 / r^2
    logic [vdw_pkg::S_W-1:0] s_q;

    vdw_div #(.WD(BW), .NQ(vdw_pkg::S_W), .BPS(DIV_BPS)) u_div_s (
        .i_clk (i_clk),
        .i_rem (BW'(a_b)),
        .i_lo  ('0),
        .i_den (r_b),
        .o_q   (s_q)
    );

    // well depth by geometric mean, then 12*D
    logic [vdw_pkg::D_W-1:0]   d_root;
    logic [vdw_pkg::D_W-1:0]   r_dd;
    logic [vdw_pkg::D12_W-1:0] r_d12;
    logic [vdw_pkg::D_W-1:0]   dd_tu;
    logic [vdw_pkg::D12_W-1:0] d12_tu;

    vdw_isqrt #(.WR(vdw_pkg::D_W), .SPS(vdw_pkg::ISQ_SPS)) u_isqrt (
        .i_clk (i_clk), .i_v (r_p), .o_r (d_root)
    );

    always_ff @(posedge i_clk) begin
        r_dd  <= d_root;
        r_d12 <= (vdw_pkg::D12_W'(d_root) << 3) + (vdw_pkg::D12_W'(d_root) << 2);
    end

    vdw_dly #(.W(vdw_pkg::D_W + vdw_pkg::D12_W), .N(T_TU - T_D)) u_dly_d (
        .i_clk (i_clk), .i_d ({r_dd, r_d12}), .o_d ({dd_tu, d12_tu})
    );

    // powers: s^2, x^6, x^12, each dropping 32 fraction bits
    logic [2*vdw_pkg::S_W-1:0]             p_s2;
    logic [vdw_pkg::S2_W+vdw_pkg::S_W-1:0] p_x6;
    logic [2*vdw_pkg::X6_W-1:0]            p_x12;
    logic [vdw_pkg::S_W-1:0]               s_d;
    logic [vdw_pkg::X6_W-1:0]              x6_d;

    vdw_mul #(.WA(vdw_pkg::S_W), .WB(vdw_pkg::S_W)) u_mul_s2 (
        .i_clk (i_clk), .i_a (s_q), .i_b (s_q), .o_p (p_s2)
    );

    vdw_dly #(.W(vdw_pkg::S_W), .N(ML)) u_dly_s (
        .i_clk (i_clk), .i_d (s_q), .o_d (s_d)
    );

    vdw_mul #(.WA(vdw_pkg::S2_W), .WB(vdw_pkg::S_W)) u_mul_x6 (
        .i_clk (i_clk), .i_a (p_s2[FW +: vdw_pkg::S2_W]), .i_b (s_d), .o_p (p_x6)
    );

    vdw_mul #(.WA(vdw_pkg::X6_W), .WB(vdw_pkg::X6_W)) u_mul_x12 (
        .i_clk (i_clk),
        .i_a   (p_x6[FW +: vdw_pkg::X6_W]),
        .i_b   (p_x6[FW +: vdw_pkg::X6_W]),
        .o_p   (p_x12)
    );

    vdw_dly #(.W(vdw_pkg::X6_W), .N(ML)) u_dly_x6 (
        .i_clk (i_clk), .i_d (p_x6[FW +: vdw_pkg::X6_W]), .o_d (x6_d)
    );

    // t = |x^12 - 2x^6| for energy, u = |x^12 - x^6| for the gradient
    logic [vdw_pkg::X12_W-1:0] x12;
    logic [vdw_pkg::X12_W-1:0] x6w;
    logic [vdw_pkg::X12_W-1:0] x6w2;
    logic [vdw_pkg::X12_W-1:0] r_t;
    logic [vdw_pkg::X12_W-1:0] r_u;
    logic                      r_eneg;
    logic                      r_uneg;
    logic                      eneg_e;
    logic                      uneg_q;

    assign x12  = p_x12[FW +: vdw_pkg::X12_W];
    assign x6w  = vdw_pkg::X12_W'(x6_d);
    assign x6w2 = vdw_pkg::X12_W'({x6_d, 1'b0});

    always_ff @(posedge i_clk) begin
        r_eneg <= x12 < x6w2;
        r_t    <= (x12 < x6w2) ? x6w2 - x12 : x12 - x6w2;
        r_uneg <= x12 < x6w;
        r_u    <= (x12 < x6w) ? x6w - x12 : x12 - x6w;
    end

    vdw_dly #(.W(1), .N(T_E - T_TU)) u_dly_eneg (
        .i_clk (i_clk), .i_d (r_eneg), .o_d (eneg_e)
    );

    vdw_dly #(.W(1), .N(T_Q - T_TU)) u_dly_uneg (
        .i_clk (i_clk), .i_d (r_uneg), .o_d (uneg_q)
    );

    // energy = D * t >> 28, saturated
    logic [vdw_pkg::X12_W+vdw_pkg::D_W-1:0] p_e;
    logic [PW:0]                            r_eclip;
    logic [PW:0]                            eclip_q;

    vdw_mul #(.WA(vdw_pkg::X12_W), .WB(vdw_pkg::D_W)) u_mul_e (
        .i_clk (i_clk), .i_a (r_t), .i_b (dd_tu), .o_p (p_e)
    );

    always_ff @(posedge i_clk) begin
        r_eclip <= f_clip(eneg_e, |p_e[vdw_pkg::X12_W+vdw_pkg::D_W-1:vdw_pkg::E_SH+PW],
                          p_e[vdw_pkg::E_SH +: PW]);
    end

    vdw_dly #(.W(PW + 1), .N(T_Q - T_EC)) u_dly_e (
        .i_clk (i_clk), .i_d (r_eclip), .o_d (eclip_q)
    );

    // gradient numerator: u * 12D * |rij_c|
    logic [vdw_pkg::UD_W-1:0] p_ud;
    logic [MW-1:0]            mag_e [3];
    logic [BW-1:0]            b_n;
    logic [BW-1:0]            r_bg;

    vdw_mul #(.WA(vdw_pkg::X12_W), .WB(vdw_pkg::D12_W)) u_mul_ud (
        .i_clk (i_clk), .i_a (r_u), .i_b (d12_tu), .o_p (p_ud)
    );

    vdw_dly #(.W(BW), .N(T_N - T_B)) u_dly_b (
        .i_clk (i_clk), .i_d (r_b), .o_d (b_n)
    );

    always_ff @(posedge i_clk) begin
        r_bg <= b_n;
    end

    logic [vdw_pkg::GQ_W-1:0] gq [3];
    logic [2:0]               gsat_q;

    for (genvar c = 0; c < 3; c++) begin : g_grad
        logic [vdw_pkg::N_W-1:0]               p_n;
        logic [vdw_pkg::N_W-vdw_pkg::GQ_W-1:0] n_hi;
        logic                                  ovf;
        logic                                  r_gsat;
        logic [BW-1:0]                         r_nhi;
        logic [vdw_pkg::GQ_W-1:0]              r_nlo;

        vdw_dly #(.W(MW), .N(T_E - T_A)) u_dly_mag (
            .i_clk (i_clk), .i_d (r_mag[c]), .o_d (mag_e[c])
        );

        vdw_mul #(.WA(vdw_pkg::UD_W), .WB(MW)) u_mul_n (
            .i_clk (i_clk), .i_a (p_ud), .i_b (mag_e[c]), .o_p (p_n)
        );

        // quotient at or above 2^44 can only saturate
        assign n_hi = p_n[vdw_pkg::N_W-1:vdw_pkg::GQ_W];
        assign ovf  = n_hi >= (vdw_pkg::N_W-vdw_pkg::GQ_W)'(b_n);

        always_ff @(posedge i_clk) begin
            r_gsat <= ovf;
            r_nhi  <= ovf ? '0 : n_hi[BW-1:0];
            r_nlo  <= p_n[vdw_pkg::GQ_W-1:0];
        end

        vdw_div #(.WD(BW), .NQ(vdw_pkg::GQ_W), .BPS(DIV_BPS)) u_div_g (
            .i_clk (i_clk),
            .i_rem (r_nhi),
            .i_lo  (r_nlo),
            .i_den (r_bg),
            .o_q   (gq[c])
        );

        vdw_dly #(.W(1), .N(T_Q - T_G)) u_dly_gsat (
            .i_clk (i_clk), .i_d (r_gsat), .o_d (gsat_q[c])
        );
    end

    vdw_dly #(.W($bits(t_side)), .N(T_Q - T_A)) u_dly_side (
        .i_clk (i_clk), .i_d (r_side), .o_d (side_q)
    );

    // final selection: skip, far, deep overlap or computed values
    logic [PW-1:0] n_energy;
    logic [PW-1:0] n_grad [3];
    logic          n_sat;
    logic [PW:0]   gclip [3];

    for (genvar c = 0; c < 3; c++) begin : g_gclip
        assign gclip[c] = f_clip((~uneg_q) ^ side_q.dneg[c], gsat_q[c],
                                 gq[c][vdw_pkg::G_SH +: PW]);
    end

    always_comb begin
        n_energy = '0;
        n_sat    = 1'b0;
        for (int c = 0; c < 3; c++) begin
            n_grad[c] = '0;
        end
        if (side_q.zero || side_q.far) begin
            n_sat = 1'b0;
        end else if (ovl_q) begin
            if (!side_q.pz) begin
                n_sat    = 1'b1;
                n_energy = vdw_pkg::POS_MAX;
                for (int c = 0; c < 3; c++) begin
                    if (side_q.dnz[c]) begin
                        n_grad[c] = side_q.dneg[c] ? vdw_pkg::POS_MAX : vdw_pkg::NEG_MAX;
                    end
                end
            end
        end else begin
            n_energy = eclip_q[PW-1:0];
            n_sat    = eclip_q[PW];
            for (int c = 0; c < 3; c++) begin
                n_grad[c] = gclip[c][PW-1:0];
                n_sat     = n_sat | gclip[c][PW];
            end
        end
    end

    // result word register
    logic [vdw_pkg::IDX_W-1:0] r_oi;
    logic [vdw_pkg::IDX_W-1:0] r_oj;
    logic [PW-1:0]             r_energy;
    logic [PW-1:0]             r_grad [3];
    logic                      r_skip;
    logic                      r_sat;

    always_ff @(posedge i_clk) begin
        r_oi     <= side_q.idx_i;
        r_oj     <= side_q.idx_j;
        r_energy <= n_energy;
        for (int c = 0; c < 3; c++) begin
            r_grad[c] <= n_grad[c];
        end
        r_skip   <= side_q.zero;
        r_sat    <= n_sat;
    end

    assign o_valid       = r_vld[T_OUT-1];
    assign o_out_atom_i  = r_oi;
    assign o_out_atom_j  = r_oj;
    assign o_pair_energy = r_energy;
    assign o_grad_x      = r_grad[0];
    assign o_grad_y      = r_grad[1];
    assign o_grad_z      = r_grad[2];
    assign o_skipped     = r_skip;
    assign o_saturated   = r_sat;

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(T_OUT) o_valid)
        else $error("accepted pair word did not emerge");

    // no result word without a start the same distance back
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, T_OUT))
        else $error("result word without a matching start");

    // a skipped pair carries zero energy and gradient, never clipped
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_skipped) |-> (o_pair_energy == '0 && o_grad_x == '0 &&
                                    o_grad_y == '0 && o_grad_z == '0 && !o_saturated))
        else $error("skipped pair with nonzero result");

endmodule

[sim/vdw_pair_energy_force_chk.sv]
// ----------------------------------------------------------------------------
// vdw_pair_energy_force_chk
// Watches the pair and result channels of the 12-6 pair energy block, predicts
// each result from the accepted pair word and compares it field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vdw_pair_energy_force_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [vdw_pkg::IDX_W-1:0]   i_atom_i_index,
    input  logic [vdw_pkg::IDX_W-1:0]   i_atom_j_index,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_i_x,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_i_y,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_i_z,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_j_x,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_j_y,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pos_j_z,
    input  logic [vdw_pkg::PRM_W-1:0]   i_dist_param_i,
    input  logic [vdw_pkg::PRM_W-1:0]   i_dist_param_j,
    input  logic [vdw_pkg::PRM_W-1:0]   i_well_depth_i,
    input  logic [vdw_pkg::PRM_W-1:0]   i_well_depth_j,
    input  logic                        i_valid,
    input  logic [vdw_pkg::IDX_W-1:0]   i_out_atom_i,
    input  logic [vdw_pkg::IDX_W-1:0]   i_out_atom_j,
    input  logic signed [vdw_pkg::POS_W-1:0] i_pair_energy,
    input  logic signed [vdw_pkg::POS_W-1:0] i_grad_x,
    input  logic signed [vdw_pkg::POS_W-1:0] i_grad_y,
    input  logic signed [vdw_pkg::POS_W-1:0] i_grad_z,
    input  logic                        i_skipped,
    input  logic                        i_saturated,
    output int                          o_fails,
    output int                          o_pending
);
    import vdw_pkg::*;

    typedef logic [255:0] wide_t;

    typedef struct {
        logic [IDX_W-1:0] atom_i;
        logic [IDX_W-1:0] atom_j;
        logic [POS_W-1:0] energy;
        logic [POS_W-1:0] grad [3];
        logic             skipped;
        logic             saturated;
    } pair_result_t;

    pair_result_t expected_results[$];
    int           fails = 0;

    assign o_fails   = fails;
    assign o_pending = expected_results.size();

    // floor(sqrt(v)) for a 32-bit product
    function automatic logic [15:0] mixed_depth(input logic [31:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= 64'(v)) root = trial;
        end
        return root[15:0];
    endfunction

    // {clipped, value}: signed Q16.16 from a sign and a magnitude
    function automatic logic [32:0] clip_q16(input bit neg, input wide_t m);
        if (!neg) begin
            if (m > wide_t'(POS_MAX)) return {1'b1, POS_MAX};
            return {1'b0, m[31:0]};
        end
        if (m > wide_t'(NEG_MAX)) return {1'b1, NEG_MAX};
        return {1'b0, 32'd0 - m[31:0]};
    endfunction

    function automatic pair_result_t predict_pair_result(
        input logic [IDX_W-1:0] ai, input logic [IDX_W-1:0] aj,
        input logic signed [POS_W-1:0] pi [3], input logic signed [POS_W-1:0] pj [3],
        input logic [PRM_W-1:0] dpi, input logic [PRM_W-1:0] dpj,
        input logic [PRM_W-1:0] wdi, input logic [PRM_W-1:0] wdj);
        pair_result_t r;
        longint       dlt [3];
        wide_t        mg [3];
        wide_t        a_sq, r_sq, dep, s, s2, x6, x12, t, u, g;
        bit           far, eneg, uneg, gneg;
        logic [32:0]  cl;
        r.atom_i = ai;
        r.atom_j = aj;
        r.energy = 0;
        r.skipped = 0;
        r.saturated = 0;
        far = 0;
        r_sq = 0;
        for (int c = 0; c < 3; c++) begin
            r.grad[c] = 0;
            dlt[c] = longint'(pi[c]) - longint'(pj[c]);
            mg[c] = wide_t'(dlt[c] < 0 ? -dlt[c] : dlt[c]);
            if (mg[c] >= wide_t'(1) << 24) far = 1;
        end
        a_sq = wide_t'(dpi) * wide_t'(dpj);
        dep = wide_t'(mixed_depth(32'(wdi) * 32'(wdj)));
        if (mg[0] == 0 && mg[1] == 0 && mg[2] == 0) begin
            // coincident atoms
            r.skipped = 1;
        end else if (!far) begin
            for (int c = 0; c < 3; c++) r_sq += mg[c] * mg[c];
            if (a_sq >= r_sq) begin
                // deep overlap: pinned at the rails when the well depth is nonzero
                if (dep != 0) begin
                    r.saturated = 1;
                    r.energy = POS_MAX;
                    for (int c = 0; c < 3; c++)
                        r.grad[c] = mg[c] == 0 ? '0 : (dlt[c] > 0 ? NEG_MAX : POS_MAX);
                end
            end else begin
                s   = (a_sq << 40) / r_sq;
                s2  = (s * s) >> 32;
                x6  = (s2 * s) >> 32;
                x12 = (x6 * x6) >> 32;
                eneg = x12 < 2 * x6;
                t = eneg ? 2 * x6 - x12 : x12 - 2 * x6;
                cl = clip_q16(eneg, (t * dep) >> 28);
                r.energy = cl[31:0];
                r.saturated = cl[32];
                uneg = x12 < x6;
                u = (uneg ? x6 - x12 : x12 - x6) * (12 * dep);
                for (int c = 0; c < 3; c++) begin
                    g = ((u * mg[c]) / r_sq) >> 12;
                    gneg = (!uneg) != (dlt[c] < 0);
                    cl = clip_q16(gneg, g);
                    r.grad[c] = cl[31:0];
                    if (cl[32]) r.saturated = 1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", field, got, want);
        fails++;
    endtask

    // predict on each accepted pair word, check each result word
    always @(posedge i_clk) begin
        pair_result_t want;
        logic signed [POS_W-1:0] pi [3];
        logic signed [POS_W-1:0] pj [3];
        logic [POS_W-1:0] got_g [3];
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                pi[0] = i_pos_i_x; pi[1] = i_pos_i_y; pi[2] = i_pos_i_z;
                pj[0] = i_pos_j_x; pj[1] = i_pos_j_y; pj[2] = i_pos_j_z;
                expected_results.insert(expected_results.size(), predict_pair_result(
                    i_atom_i_index, i_atom_j_index, pi, pj, i_dist_param_i,
                    i_dist_param_j, i_well_depth_i, i_well_depth_j));
            end
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result word", 32'(i_out_atom_i), 0);
                end else begin
                    want = expected_results.pop_front();
                    got_g[0] = i_grad_x; got_g[1] = i_grad_y; got_g[2] = i_grad_z;
                    if (i_out_atom_i !== want.atom_i)
                        report_mismatch("out_atom_i", 32'(i_out_atom_i), 32'(want.atom_i));
                    if (i_out_atom_j !== want.atom_j)
                        report_mismatch("out_atom_j", 32'(i_out_atom_j), 32'(want.atom_j));
                    if (i_pair_energy !== want.energy)
                        report_mismatch("pair_energy", i_pair_energy, want.energy);
                    for (int c = 0; c < 3; c++)
                        if (got_g[c] !== want.grad[c])
                            report_mismatch($sformatf("grad[%0d]", c), got_g[c], want.grad[c]);
                    if (i_skipped !== want.skipped)
                        report_mismatch("skipped", 32'(i_skipped), 32'(want.skipped));
                    if (i_saturated !== want.saturated)
                        report_mismatch("saturated", 32'(i_saturated), 32'(want.saturated));
                end
            end
        end
    end

endmodule

[sim/vdw_pair_energy_force_tb.sv]
// ----------------------------------------------------------------------------
// vdw_pair_energy_force_tb
// Drives directed and random atom pairs into the 12-6 pair energy block with
// random gaps, lets the checker predict and compare every result word, and
// gives the verdict once all words have drained.
// ----------------------------------------------------------------------------
module vdw_pair_energy_force_tb;
    import vdw_pkg::*;

    localparam int N_RANDOM   = 1530;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 60;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic o_busy;
    logic [IDX_W-1:0] i_atom_i_index = 0, i_atom_j_index = 0;
    logic signed [POS_W-1:0] i_pos_i_x = 0, i_pos_i_y = 0, i_pos_i_z = 0;
    logic signed [POS_W-1:0] i_pos_j_x = 0, i_pos_j_y = 0, i_pos_j_z = 0;
    logic [PRM_W-1:0] i_dist_param_i = 0, i_dist_param_j = 0;
    logic [PRM_W-1:0] i_well_depth_i = 0, i_well_depth_j = 0;
    logic o_valid;
    logic [IDX_W-1:0] o_out_atom_i, o_out_atom_j;
    logic signed [POS_W-1:0] o_pair_energy, o_grad_x, o_grad_y, o_grad_z;
    logic o_skipped, o_saturated;
    int   fail_count, pending_words;
    int   idle_cycles = 0;
    bit   no_gaps = 0;

    always #4 i_clk = ~i_clk;

    vdw_pair_energy_force u_top (.*);

    vdw_pair_energy_force_chk u_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_atom_i_index, .i_atom_j_index,
        .i_pos_i_x, .i_pos_i_y, .i_pos_i_z, .i_pos_j_x, .i_pos_j_y, .i_pos_j_z,
        .i_dist_param_i, .i_dist_param_j, .i_well_depth_i, .i_well_depth_j,
        .i_valid(o_valid), .i_out_atom_i(o_out_atom_i), .i_out_atom_j(o_out_atom_j),
        .i_pair_energy(o_pair_energy), .i_grad_x(o_grad_x), .i_grad_y(o_grad_y),
        .i_grad_z(o_grad_z), .i_skipped(o_skipped), .i_saturated(o_saturated),
        .o_fails(fail_count), .o_pending(pending_words)
    );

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one pair word and hold it until taken, then maybe idle
    task automatic send_pair(input logic [IDX_W-1:0] ai, input logic [IDX_W-1:0] aj,
                             input logic [31:0] pix, input logic [31:0] piy,
                             input logic [31:0] piz, input logic [31:0] pjx,
                             input logic [31:0] pjy, input logic [31:0] pjz,
                             input logic [15:0] dpi, input logic [15:0] dpj,
                             input logic [15:0] wdi, input logic [15:0] wdj);
        int roll;
        int gap;
        i_start <= 1;
        i_atom_i_index <= ai; i_atom_j_index <= aj;
        i_pos_i_x <= pix; i_pos_i_y <= piy; i_pos_i_z <= piz;
        i_pos_j_x <= pjx; i_pos_j_y <= pjy; i_pos_j_z <= pjz;
        i_dist_param_i <= dpi; i_dist_param_j <= dpj;
        i_well_depth_i <= wdi; i_well_depth_j <= wdj;
        do @(posedge i_clk); while (o_busy);
        roll = $urandom_range(0, 99);
        gap = no_gaps || roll < 55 ? 0 : (roll < 92 ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 60));
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // signed offset of random scale, mostly inside the far limit
    function automatic logic [31:0] rand_offset();
        int w;
        logic [31:0] v;
        w = $urandom_range(0, 25);
        v = $urandom & ((32'd1 << w) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [15:0] rand_param();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 0;
        if (k == 1) return 16'hFFFF;
        if (k < 6) return 16'h2000 + 16'($urandom_range(0, 16'h3000));
        return 16'($urandom);
    endfunction

    initial begin
        logic [31:0] bx, by, bz;
        int kind;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: special cases and field extremes
        send_pair(0, 12'hFFF, 0, 0, 0, 0, 0, 0, 16'h3800, 16'h3800, 16'h1000, 16'h1000);
        send_pair(12'hFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 5, 32'h7FFF_FFFF,
                  32'h8000_0000, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(1, 2, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                  16'h4000, 16'h4000, 16'h1000, 16'h1000);
        send_pair(3, 4, 32'h0100_0000, 0, 0, 0, 0, 0, 16'h4000, 16'h4000, 16'h1000, 16'h1000);
        send_pair(5, 6, 32'h00FF_FFFF, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(7, 8, 0, 0, 32'h0001_0000, 0, 0, 0, 16'h4000, 16'h4000, 16'h1000, 16'h1000);
        send_pair(9, 10, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0,
                  16'h4000, 16'h4000, 0, 16'hFFFF);
        send_pair(11, 12, 32'h0004_0000, 0, 0, 0, 0, 0, 16'h4000, 16'h4000, 16'h1000, 16'h1000);
        send_pair(13, 14, 32'h0004_8000, 32'h0000_8000, 32'hFFFF_8000, 0, 0, 0,
                  16'h4000, 16'h4000, 16'h1000, 16'h1000);
        send_pair(15, 16, 0, 32'h0003_8000, 0, 0, 0, 0, 16'h3800, 16'h3800, 16'h2000, 16'h0800);
        send_pair(17, 18, 0, 0, 1, 0, 0, 0, 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_pair(19, 20, 0, 0, 1, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        send_pair(21, 22, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, 0, 0,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(23, 24, 32'h0000_2000, 0, 0, 0, 0, 0, 16'h0800, 16'h0800, 16'hFFFF, 16'hFFFF);
        send_pair(25, 26, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);

        // random: mostly nearby pairs, some coincident, far or raw noise
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 300 == 0) no_gaps = $urandom_range(0, 2) == 0;
            kind = $urandom_range(0, 99);
            bx = $urandom; by = $urandom; bz = $urandom;
            if (kind < 6)
                send_pair(IDX_W'($urandom), IDX_W'($urandom), bx, by, bz, bx, by, bz,
                          rand_param(), rand_param(), rand_param(), rand_param());
            else if (kind < 16)
                send_pair(IDX_W'($urandom), IDX_W'($urandom), bx, by, bz,
                          $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_pair(IDX_W'($urandom), IDX_W'($urandom), bx, by, bz, bx - rand_offset(),
                          by - rand_offset(), bz - rand_offset(),
                          rand_param(), rand_param(), rand_param(), rand_param());
        end
        i_start <= 0;

        // drain, then allow for any stray words
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
